### src/fun_pkg.sv
// Package for the face unit normal core: widths, item types and pipeline constants.
package fun_pkg;

  localparam int COORD_BITS       = 12;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORM_BITS        = 16;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int LEN_W   = $clog2(MAG_W + 1);

  localparam int SUMSQ_W = 2 * NORM_BITS + 2;
  localparam int RAD_PAD = 16;
  localparam int RAD_W   = SUMSQ_W + RAD_PAD;
  localparam int ROOT_W  = RAD_W / 2;

  localparam int OUT_W   = NORMAL_FRAC_BITS + 2;
  localparam int QUO_W   = OUT_W;
  localparam int REM_W   = ROOT_W + 1;
  localparam int NUM_SH  = NORMAL_FRAC_BITS + 8;
  localparam int PRE_SH  = NUM_SH - QUO_W;
  localparam int UNIT    = 2 ** NORMAL_FRAC_BITS;

  localparam int FRONT_STAGES = 9;
  localparam int LATENCY      = FRONT_STAGES + ROOT_W + QUO_W + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    degenerate;
  } out_item_t;

  // Per-item sideband carried through the root and divide pipelines.
  typedef struct packed {
    logic                       degen;
    logic [2:0]                 neg;
    logic [2:0][NORM_BITS-1:0]  m;
  } side_t;

endpackage

### src/face_unit_normal_core.sv
// Top level: face unit normal pipeline (cross product, normalize, root, divide).
// Path from the accepting edge until out_valid is seen high: 9 front stages,
// 25 root stages, 16 divide stages, 1 output register.
// Throughput: one item per cycle; fully pipelined, busy is always low.
// The receiver cannot stall; out_valid strobes for one cycle per item.
// Reset: synchronous active-low rst_n clears all valid bits; data regs keep.
module face_unit_normal_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  fun_pkg::in_item_t    in_item,
  output logic                 busy,
  output logic                 out_valid,
  output fun_pkg::out_item_t   out_item
);

  localparam int DW  = fun_pkg::DIFF_W;
  localparam int PW  = fun_pkg::PROD_W;
  localparam int CW  = fun_pkg::CROSS_W;
  localparam int MW  = fun_pkg::MAG_W;
  localparam int LW  = fun_pkg::LEN_W;
  localparam int NB  = fun_pkg::NORM_BITS;
  localparam int SW  = fun_pkg::SUMSQ_W;

  // No stall anywhere, so a new item is taken every cycle.
  assign busy = 1'b0;

  logic acc;
  assign acc = start && !busy;

  // s1: edge vectors u = b - a, w = c - a
  logic                 v1_r;
  logic signed [DW-1:0] u_r [3];
  logic signed [DW-1:0] w_r [3];

  // s2: six partial products of the cross product
  logic                 v2_r;
  logic signed [PW-1:0] p_r [6];

  // s3: cross product
  logic                 v3_r;
  logic signed [CW-1:0] n_r [3];

  // s4: magnitude and sign
  logic                 v4_r;
  logic [MW-1:0]        a4_r [3];
  logic [2:0]           neg4_r;

  // s5: largest magnitude
  logic                 v5_r;
  logic [MW-1:0]        a5_r [3];
  logic [2:0]           neg5_r;
  logic [MW-1:0]        big_r;

  // s6: bit length of the largest
  logic                 v6_r;
  logic [MW-1:0]        a6_r [3];
  logic [2:0]           neg6_r;
  logic [LW-1:0]        len_r;

  // s7: normalized magnitudes (largest lands in [2^15, 2^16))
  logic                 v7_r;
  fun_pkg::side_t       side7_r;

  // s8: squares
  logic                 v8_r;
  fun_pkg::side_t       side8_r;
  logic [2*NB-1:0]      sq_r [3];

  // s9: sum of squares
  logic                 v9_r;
  fun_pkg::side_t       side9_r;
  logic [SW-1:0]        sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  // Combinational next values for the data path
  logic [LW-1:0]   len_nxt;
  fun_pkg::side_t  side7_nxt;
  logic [MW-1:0]   big_nxt;

  always_comb begin
    big_nxt = a4_r[0];
    if (a4_r[1] > big_nxt) begin
      big_nxt = a4_r[1];
    end
    if (a4_r[2] > big_nxt) begin
      big_nxt = a4_r[2];
    end
  end

  always_comb begin
    len_nxt = '0;
    for (int i = 0; i < MW; i++) begin
      if (big_r[i]) begin
        len_nxt = LW'(i + 1);
      end
    end
  end

  always_comb begin
    logic [MW-1:0] sh;
    side7_nxt.neg   = neg6_r;
    side7_nxt.degen = (len_r == '0);
    for (int l = 0; l < 3; l++) begin
      if (int'(len_r) <= NB) begin
        sh = a6_r[l] << (NB - int'(len_r));
      end else begin
        sh = a6_r[l] >> (int'(len_r) - NB);
      end
      side7_nxt.m[l] = sh[NB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    // s1
    u_r[0] <= DW'(in_item.b_x) - DW'(in_item.a_x);
    u_r[1] <= DW'(in_item.b_y) - DW'(in_item.a_y);
    u_r[2] <= DW'(in_item.b_z) - DW'(in_item.a_z);
    w_r[0] <= DW'(in_item.c_x) - DW'(in_item.a_x);
    w_r[1] <= DW'(in_item.c_y) - DW'(in_item.a_y);
    w_r[2] <= DW'(in_item.c_z) - DW'(in_item.a_z);
    // s2
    p_r[0] <= u_r[1] * w_r[2];
    p_r[1] <= u_r[2] * w_r[1];
    p_r[2] <= u_r[2] * w_r[0];
    p_r[3] <= u_r[0] * w_r[2];
    p_r[4] <= u_r[0] * w_r[1];
    p_r[5] <= u_r[1] * w_r[0];
    // s3
    n_r[0] <= CW'(p_r[0]) - CW'(p_r[1]);
    n_r[1] <= CW'(p_r[2]) - CW'(p_r[3]);
    n_r[2] <= CW'(p_r[4]) - CW'(p_r[5]);
    // s4
    for (int l = 0; l < 3; l++) begin
      neg4_r[l] <= n_r[l][CW-1];
      a4_r[l]   <= n_r[l][CW-1] ? MW'(-n_r[l]) : MW'(n_r[l]);
    end
    // s5
    a5_r   <= a4_r;
    neg5_r <= neg4_r;
    big_r  <= big_nxt;
    // s6
    a6_r   <= a5_r;
    neg6_r <= neg5_r;
    len_r  <= len_nxt;
    // s7
    side7_r <= side7_nxt;
    // s8
    side8_r <= side7_r;
    for (int l = 0; l < 3; l++) begin
      sq_r[l] <= side7_r.m[l] * side7_r.m[l];
    end
    // s9
    side9_r <= side8_r;
    sum_r   <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
  end

  // Root of the sum of squares, scaled by 2^8
  logic                         rt_vld;
  fun_pkg::side_t               rt_side;
  logic [fun_pkg::ROOT_W-1:0]   rt_val;

  fun_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v9_r),
    .in_side  (side9_r),
    .in_sumsq (sum_r),
    .out_vld  (rt_vld),
    .out_side (rt_side),
    .out_root (rt_val)
  );

  // Per-component divide by the magnitude
  logic                 dv_vld;
  fun_pkg::out_item_t   dv_res;

  fun_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rt_vld),
    .in_side (rt_side),
    .in_root (rt_val),
    .out_vld (dv_vld),
    .out_res (dv_res)
  );

  // Output register: one-cycle strobe per item
  logic               out_valid_r;
  fun_pkg::out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= dv_res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### src/fun_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module fun_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  fun_pkg::side_t                in_side,
  input  logic [fun_pkg::SUMSQ_W-1:0]   in_sumsq,
  output logic                          out_vld,
  output fun_pkg::side_t                out_side,
  output logic [fun_pkg::ROOT_W-1:0]    out_root
);

  localparam int RW = fun_pkg::RAD_W;
  localparam int NS = fun_pkg::ROOT_W;

  logic           vld_r  [NS];
  fun_pkg::side_t side_r [NS];
  logic [RW-1:0]  x_r    [NS];
  logic [RW-1:0]  rt_r   [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam logic [RW:0] BIT = {{RW{1'b0}}, 1'b1} << (2 * (NS - 1 - k));
    logic           v_i;
    fun_pkg::side_t s_i;
    logic [RW-1:0]  x_i, rt_i, x_nxt, rt_nxt;
    logic [RW:0]    trial;

    if (k == 0) begin : g_first
      assign v_i  = in_vld;
      assign s_i  = in_side;
      assign x_i  = {in_sumsq, {fun_pkg::RAD_PAD{1'b0}}};
      assign rt_i = '0;
    end else begin : g_next
      assign v_i  = vld_r[k-1];
      assign s_i  = side_r[k-1];
      assign x_i  = x_r[k-1];
      assign rt_i = rt_r[k-1];
    end

    always_comb begin
      trial = {1'b0, rt_i} + BIT;
      if ({1'b0, x_i} >= trial) begin
        x_nxt  = x_i - trial[RW-1:0];
        rt_nxt = (rt_i >> 1) + BIT[RW-1:0];
      end else begin
        x_nxt  = x_i;
        rt_nxt = rt_i >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      side_r[k] <= s_i;
      x_r[k]    <= x_nxt;
      rt_r[k]   <= rt_nxt;
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_side = side_r[NS-1];
  assign out_root = rt_r[NS-1][NS-1:0];

endmodule

### src/fun_div.sv
// Three-lane pipelined restoring divider with rounding, clamp and sign.
module fun_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  fun_pkg::side_t              in_side,
  input  logic [fun_pkg::ROOT_W-1:0]  in_root,
  output logic                        out_vld,
  output fun_pkg::out_item_t          out_res
);

  localparam int NQ  = fun_pkg::QUO_W;
  localparam int RMW = fun_pkg::REM_W;
  localparam int MW  = fun_pkg::ROOT_W;
  localparam int OW  = fun_pkg::OUT_W;

  logic           vld_r  [NQ];
  fun_pkg::side_t side_r [NQ];
  logic [MW-1:0]  mag_r  [NQ];
  logic [RMW-1:0] rem_r  [NQ][3];
  logic [NQ-1:0]  q_r    [NQ][3];

  for (genvar j = 0; j < NQ; j++) begin : g_step
    logic           v_i;
    fun_pkg::side_t s_i;
    logic [MW-1:0]  mag_i;
    logic [RMW-1:0] rem_i   [3];
    logic [NQ-1:0]  q_i     [3];
    logic [RMW-1:0] rem_nxt [3];
    logic [NQ-1:0]  q_nxt   [3];

    if (j == 0) begin : g_first
      assign v_i   = in_vld;
      assign s_i   = in_side;
      assign mag_i = in_root;
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_i[l] = RMW'({in_side.m[l], {fun_pkg::PRE_SH{1'b0}}});
          q_i[l]   = '0;
        end
      end
    end else begin : g_next
      assign v_i   = vld_r[j-1];
      assign s_i   = side_r[j-1];
      assign mag_i = mag_r[j-1];
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_i[l] = rem_r[j-1][l];
          q_i[l]   = q_r[j-1][l];
        end
      end
    end

    always_comb begin
      logic [RMW-1:0] sh;
      logic           ge;
      for (int l = 0; l < 3; l++) begin
        sh         = {rem_i[l][RMW-2:0], 1'b0};
        ge         = sh >= {1'b0, mag_i};
        rem_nxt[l] = ge ? sh - {1'b0, mag_i} : sh;
        q_nxt[l]   = {q_i[l][NQ-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else begin
        vld_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      side_r[j] <= s_i;
      mag_r[j]  <= mag_i;
      for (int l = 0; l < 3; l++) begin
        rem_r[j][l] <= rem_nxt[l];
        q_r[j][l]   <= q_nxt[l];
      end
    end
  end

  // Round half up on the remainder, clamp to one, apply sign; degenerate items give zero.
  logic [OW-1:0] comp [3];

  always_comb begin
    logic [NQ:0]   qr;
    logic [OW-1:0] val;
    for (int l = 0; l < 3; l++) begin
      qr = {1'b0, q_r[NQ-1][l]}
         + (NQ+1)'({rem_r[NQ-1][l], 1'b0} >= {2'b0, mag_r[NQ-1]});
      if (qr > (NQ+1)'(fun_pkg::UNIT)) begin
        qr = (NQ+1)'(fun_pkg::UNIT);
      end
      val = qr[OW-1:0];
      if (side_r[NQ-1].degen) begin
        comp[l] = '0;
      end else if (side_r[NQ-1].neg[l]) begin
        comp[l] = -val;
      end else begin
        comp[l] = val;
      end
    end
  end

  assign out_vld            = vld_r[NQ-1];
  assign out_res.normal_x   = comp[0];
  assign out_res.normal_y   = comp[1];
  assign out_res.normal_z   = comp[2];
  assign out_res.degenerate = side_r[NQ-1].degen;

  logic unused_side;
  assign unused_side = ^side_r[NQ-1].m;

endmodule

### src/fun_chk.sv
// Port-level checker for the face unit normal core, bound to the top level.
module fun_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input fun_pkg::out_item_t out_item
);

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy == 1'b0)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(fun_pkg::LATENCY) out_valid)
    else $error("item result missing");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, fun_pkg::LATENCY))
    else $error("result without item");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.degenerate |->
      out_item.normal_x == '0 && out_item.normal_y == '0 && out_item.normal_z == '0)
    else $error("degenerate result not zero");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.degenerate |->
      out_item.normal_x <= fun_pkg::UNIT && out_item.normal_x >= -fun_pkg::UNIT &&
      out_item.normal_y <= fun_pkg::UNIT && out_item.normal_y >= -fun_pkg::UNIT &&
      out_item.normal_z <= fun_pkg::UNIT && out_item.normal_z >= -fun_pkg::UNIT)
    else $error("component out of range");

endmodule

bind face_unit_normal_core fun_chk u_fun_chk (.*);
